// File: rtl/lcf_pkg.sv
// Shared constants for the linear color fade: channel count, command codes and register map.
package lcf_pkg;

    localparam int NUM_CH = 6;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [IDX_W-1:0] REG_TARGET_PRIM_RED   = 3'd0;
    localparam logic [IDX_W-1:0] REG_TARGET_PRIM_GREEN = 3'd1;
    localparam logic [IDX_W-1:0] REG_TARGET_PRIM_BLUE  = 3'd2;
    localparam logic [IDX_W-1:0] REG_TARGET_ENV_RED    = 3'd3;
    localparam logic [IDX_W-1:0] REG_TARGET_ENV_GREEN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_TARGET_ENV_BLUE   = 3'd5;
    localparam logic [IDX_W-1:0] REG_FADE_TICKS        = 3'd6;

endpackage

// File: rtl/lcf_lane.sv
// One blend lane: scales the color difference by the elapsed count and divides bit-serially.
module lcf_lane #(
    parameter int COLOR_BITS = 8,
    parameter int TICK_BITS  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [COLOR_BITS-1:0] i_from,
    input  logic [COLOR_BITS-1:0] i_to,
    input  logic [TICK_BITS-1:0]  i_num,
    input  logic [TICK_BITS-1:0]  i_den,
    output logic                  o_done,
    output logic [COLOR_BITS-1:0] o_color
);

    localparam int DIFF_W = COLOR_BITS + 1;
    localparam int DIV_W  = COLOR_BITS + TICK_BITS;
    localparam int CNT_W  = $clog2(DIV_W + 1);

    logic signed [DIFF_W-1:0] diff;
    logic        [COLOR_BITS-1:0] diff_abs;
    logic        [DIV_W-1:0]  product;
    logic        [TICK_BITS:0] rem_shift;
    logic                     rem_ge;

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic [DIV_W-1:0]         r_quo;
    logic [TICK_BITS-1:0]     r_rem;
    logic [TICK_BITS-1:0]     r_den;
    logic [COLOR_BITS-1:0]    r_from;
    logic                     r_neg;

    always_comb begin
        diff     = $signed({1'b0, i_to}) - $signed({1'b0, i_from});
        diff_abs = diff[DIFF_W-1] ? COLOR_BITS'(-diff) : COLOR_BITS'(diff);
        product  = DIV_W'(diff_abs) * DIV_W'(i_num);
        rem_shift = {r_rem, r_quo[DIV_W-1]};
        rem_ge    = rem_shift >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_quo  <= product;
            r_rem  <= '0;
            r_den  <= i_den;
            r_from <= i_from;
            r_neg  <= diff[DIFF_W-1];
        end else if (r_busy) begin
            r_rem <= rem_ge ? TICK_BITS'(rem_shift - {1'b0, r_den})
                            : rem_shift[TICK_BITS-1:0];
            r_quo <= {r_quo[DIV_W-2:0], rem_ge};
        end
    end

    assign o_done  = r_done;
    assign o_color = r_neg ? (r_from - r_quo[COLOR_BITS-1:0])
                           : (r_from + r_quo[COLOR_BITS-1:0]);

endmodule

// File: rtl/linear_color_fade.sv
// Top level of the six-channel linear color fade with its register port and output stage.
// A fade step is computed by the bit-serial divider in each of the six lanes,
// which run side by side.
// A held or zero-length fade skips the lanes and emits the target colors as its result.
// One item is in flight at a time; the next is taken the cycle after the result is registered.
// Synchronous active-low reset clears the registers, start colors, tick count and output valid.
module linear_color_fade #(
    parameter int COLOR_BITS = 8,
    parameter int TICK_BITS  = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcf_pkg::ADDR_W-1:0]    paddr,
    input  logic [lcf_pkg::DATA_W-1:0]    pwdata,
    output logic [lcf_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [COLOR_BITS-1:0]         i_now_prim_red,
    input  logic [COLOR_BITS-1:0]         i_now_prim_green,
    input  logic [COLOR_BITS-1:0]         i_now_prim_blue,
    input  logic [COLOR_BITS-1:0]         i_now_env_red,
    input  logic [COLOR_BITS-1:0]         i_now_env_green,
    input  logic [COLOR_BITS-1:0]         i_now_env_blue,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [COLOR_BITS-1:0]         o_out_prim_red,
    output logic [COLOR_BITS-1:0]         o_out_prim_green,
    output logic [COLOR_BITS-1:0]         o_out_prim_blue,
    output logic [COLOR_BITS-1:0]         o_out_env_red,
    output logic [COLOR_BITS-1:0]         o_out_env_green,
    output logic [COLOR_BITS-1:0]         o_out_env_blue,
    output logic                          o_fade_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    t_state                   r_state;
    logic [COLOR_BITS-1:0]    r_target    [lcf_pkg::NUM_CH];
    logic [TICK_BITS-1:0]     r_fade_ticks;
    logic [COLOR_BITS-1:0]    r_start     [lcf_pkg::NUM_CH];
    logic [TICK_BITS-1:0]     r_elapsed;
    logic                     r_hold;
    logic                     r_done;
    logic                     r_lane_go;
    logic                     r_out_valid;
    logic                     r_out_done;
    logic [COLOR_BITS-1:0]    r_out_color [lcf_pkg::NUM_CH];

    logic [COLOR_BITS-1:0]    now_color   [lcf_pkg::NUM_CH];
    logic [COLOR_BITS-1:0]    lane_color  [lcf_pkg::NUM_CH];
    logic [lcf_pkg::NUM_CH-1:0] lane_done;
    logic [lcf_pkg::IDX_W-1:0]  reg_idx;
    logic                     cfg_write;
    logic [TICK_BITS-1:0]     elapsed_base;
    logic [TICK_BITS-1:0]     elapsed_inc;
    logic                     hold;
    logic                     out_free;

    assign now_color[0] = i_now_prim_red;
    assign now_color[1] = i_now_prim_green;
    assign now_color[2] = i_now_prim_blue;
    assign now_color[3] = i_now_env_red;
    assign now_color[4] = i_now_env_green;
    assign now_color[5] = i_now_env_blue;

    assign reg_idx   = paddr[lcf_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lcf_pkg::NUM_CH; i++) begin
                r_target[i] <= '0;
            end
            r_fade_ticks <= '0;
        end else if (cfg_write) begin
            if (reg_idx <= lcf_pkg::REG_TARGET_ENV_BLUE) begin
                r_target[reg_idx] <= pwdata[COLOR_BITS-1:0];
            end else if (reg_idx == lcf_pkg::REG_FADE_TICKS) begin
                r_fade_ticks <= pwdata[TICK_BITS-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx <= lcf_pkg::REG_TARGET_ENV_BLUE) begin
            prdata = {{(lcf_pkg::DATA_W-COLOR_BITS){1'b0}}, r_target[reg_idx]};
        end else if (reg_idx == lcf_pkg::REG_FADE_TICKS) begin
            prdata = {{(lcf_pkg::DATA_W-TICK_BITS){1'b0}}, r_fade_ticks};
        end
    end

    always_comb begin
        elapsed_base = (i_command == lcf_pkg::CMD_START) ? '0 : r_elapsed;
        hold         = (r_fade_ticks == '0) || (elapsed_base >= r_fade_ticks);
        elapsed_inc  = TICK_BITS'(elapsed_base + 1'b1);
        out_free     = !r_out_valid || !i_out_stall;
    end

    for (genvar g = 0; g < lcf_pkg::NUM_CH; g++) begin : g_lane
        lcf_lane #(
            .COLOR_BITS (COLOR_BITS),
            .TICK_BITS  (TICK_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_go    (r_lane_go),
            .i_from  (r_start[g]),
            .i_to    (r_target[g]),
            .i_num   (r_elapsed),
            .i_den   (r_fade_ticks),
            .o_done  (lane_done[g]),
            .o_color (lane_color[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lane_go   <= 1'b0;
            r_out_valid <= 1'b0;
            r_elapsed   <= '0;
            for (int i = 0; i < lcf_pkg::NUM_CH; i++) begin
                r_start[i] <= '0;
            end
        end else begin
            r_lane_go <= 1'b0;
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_command == lcf_pkg::CMD_START) begin
                            for (int i = 0; i < lcf_pkg::NUM_CH; i++) begin
                                r_start[i] <= now_color[i];
                            end
                        end
                        if (hold) begin
                            r_elapsed <= elapsed_base;
                            r_hold    <= 1'b1;
                            r_done    <= 1'b1;
                            r_state   <= S_EMIT;
                        end else begin
                            r_elapsed <= elapsed_inc;
                            r_hold    <= 1'b0;
                            r_done    <= (elapsed_inc == r_fade_ticks);
                            r_lane_go <= 1'b1;
                            r_state   <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    if (&lane_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        for (int i = 0; i < lcf_pkg::NUM_CH; i++) begin
                            r_out_color[i] <= r_hold ? r_target[i] : lane_color[i];
                        end
                        r_out_done  <= r_done;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_out_prim_red   = r_out_color[0];
    assign o_out_prim_green = r_out_color[1];
    assign o_out_prim_blue  = r_out_color[2];
    assign o_out_env_red    = r_out_color[3];
    assign o_out_env_green  = r_out_color[4];
    assign o_out_env_blue   = r_out_color[5];
    assign o_fade_done      = r_out_done;

endmodule

// File: rtl/lcf_checker.sv
// Port-level checker for the linear color fade, bound to the top level.
module lcf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall
);

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("Result valid dropped while stalled.");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input taken again right after an accepted item.");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("Result appeared with no item in flight.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid not cleared by reset.");

endmodule

bind linear_color_fade lcf_checker u_lcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);

// File: sim/linear_color_fade_tb.sv
// Self-checking testbench for linear_color_fade: predicted fades against results under random gaps.
`timescale 1ns / 100ps

module linear_color_fade_tb;

    localparam int COLOR_BITS = 8;
    localparam int TICK_BITS  = 12;
    localparam int RANDOM_ITEMS = 1420;

    typedef logic [lcf_pkg::NUM_CH-1:0][COLOR_BITS-1:0] t_color_set;

    typedef struct packed {
        logic       cmd;
        t_color_set now;
    } t_fade_cmd;

    typedef struct packed {
        t_color_set col;
        logic       done;
    } t_blend;

    localparam logic [lcf_pkg::IDX_W-1:0] TARGET_REGS [lcf_pkg::NUM_CH] = '{
        lcf_pkg::REG_TARGET_PRIM_RED, lcf_pkg::REG_TARGET_PRIM_GREEN,
        lcf_pkg::REG_TARGET_PRIM_BLUE, lcf_pkg::REG_TARGET_ENV_RED,
        lcf_pkg::REG_TARGET_ENV_GREEN, lcf_pkg::REG_TARGET_ENV_BLUE
    };
    localparam string CH_NAME [lcf_pkg::NUM_CH] = '{
        "prim_red", "prim_green", "prim_blue", "env_red", "env_green", "env_blue"
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [lcf_pkg::ADDR_W-1:0]    paddr = '0;
    logic [lcf_pkg::DATA_W-1:0]    pwdata = '0;
    logic [lcf_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_command = lcf_pkg::CMD_TICK;
    logic [COLOR_BITS-1:0]         i_now_prim_red = '0;
    logic [COLOR_BITS-1:0]         i_now_prim_green = '0;
    logic [COLOR_BITS-1:0]         i_now_prim_blue = '0;
    logic [COLOR_BITS-1:0]         i_now_env_red = '0;
    logic [COLOR_BITS-1:0]         i_now_env_green = '0;
    logic [COLOR_BITS-1:0]         i_now_env_blue = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [COLOR_BITS-1:0]         o_out_prim_red;
    logic [COLOR_BITS-1:0]         o_out_prim_green;
    logic [COLOR_BITS-1:0]         o_out_prim_blue;
    logic [COLOR_BITS-1:0]         o_out_env_red;
    logic [COLOR_BITS-1:0]         o_out_env_green;
    logic [COLOR_BITS-1:0]         o_out_env_blue;
    logic                          o_fade_done;

    linear_color_fade #(
        .COLOR_BITS(COLOR_BITS),
        .TICK_BITS (TICK_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_now_prim_red  (i_now_prim_red),
        .i_now_prim_green(i_now_prim_green),
        .i_now_prim_blue (i_now_prim_blue),
        .i_now_env_red   (i_now_env_red),
        .i_now_env_green (i_now_env_green),
        .i_now_env_blue  (i_now_env_blue),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_prim_red  (o_out_prim_red),
        .o_out_prim_green(o_out_prim_green),
        .o_out_prim_blue (o_out_prim_blue),
        .o_out_env_red   (o_out_env_red),
        .o_out_env_green (o_out_env_green),
        .o_out_env_blue  (o_out_env_blue),
        .o_fade_done     (o_fade_done)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Register mirror and fade state of the predictor.
    t_color_set           tgt_color = '0;
    logic [TICK_BITS-1:0] fade_len = '0;
    t_color_set           snap_color = '0;
    logic [TICK_BITS-1:0] ticks_done = '0;

    t_fade_cmd   fade_cmds[$];
    t_blend      due_blends[$];
    t_fade_cmd   cur_cmd;
    int unsigned queued = 0;
    int unsigned fed = 0;
    int unsigned starts_fed = 0;
    int unsigned blends_seen = 0;
    int unsigned settings_used = 0;
    int unsigned errors = 0;
    int unsigned in_gap = 0;
    int unsigned stall_left = 0;
    logic        no_gaps = 1'b0;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function automatic t_blend advance_fade(input t_fade_cmd it);
        t_blend r;
        int     diff;
        int     step;
        if (it.cmd == lcf_pkg::CMD_START) begin
            snap_color = it.now;
            ticks_done = '0;
        end
        if (fade_len == 0 || ticks_done >= fade_len) begin
            r.col  = tgt_color;
            r.done = 1'b1;
        end else begin
            ticks_done = ticks_done + 1'b1;
            for (int c = 0; c < lcf_pkg::NUM_CH; c++) begin
                diff = int'(tgt_color[c]) - int'(snap_color[c]);
                step = (diff * int'(ticks_done)) / int'(fade_len);
                r.col[c] = COLOR_BITS'(int'(snap_color[c]) + step);
            end
            r.done = (ticks_done >= fade_len);
        end
        return r;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                due_blends.push_back(advance_fade(cur_cmd));
                fed++;
                if (cur_cmd.cmd == lcf_pkg::CMD_START) starts_fed++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (fade_cmds.size() > 0) begin
                    cur_cmd = fade_cmds.pop_front();
                    i_command        <= cur_cmd.cmd;
                    i_now_prim_red   <= cur_cmd.now[0];
                    i_now_prim_green <= cur_cmd.now[1];
                    i_now_prim_blue  <= cur_cmd.now[2];
                    i_now_env_red    <= cur_cmd.now[3];
                    i_now_env_green  <= cur_cmd.now[4];
                    i_now_env_blue   <= cur_cmd.now[5];
                    i_in_valid       <= 1'b1;
                    in_gap = gap_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_blend();
        t_blend got;
        t_blend want;
        got.col[0] = o_out_prim_red;
        got.col[1] = o_out_prim_green;
        got.col[2] = o_out_prim_blue;
        got.col[3] = o_out_env_red;
        got.col[4] = o_out_env_green;
        got.col[5] = o_out_env_blue;
        got.done   = o_fade_done;
        if (due_blends.size() == 0) begin
            report_mismatch("result arrived with no item outstanding");
            return;
        end
        want = due_blends.pop_front();
        blends_seen++;
        for (int c = 0; c < lcf_pkg::NUM_CH; c++) begin
            if (got.col[c] !== want.col[c])
                report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                    blends_seen, CH_NAME[c], got.col[c], want.col[c]));
        end
        if (got.done !== want.done)
            report_mismatch($sformatf("result %0d fade_done: got %b, want %b",
                blends_seen, got.done, want.done));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) check_blend();
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = gap_len();
            end
        end
    end

    task automatic write_reg(input logic [lcf_pkg::IDX_W-1:0] idx, input int unsigned val);
        logic [lcf_pkg::DATA_W-1:0] want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == lcf_pkg::REG_FADE_TICKS) begin
            fade_len = val[TICK_BITS-1:0];
            want = lcf_pkg::DATA_W'(fade_len);
        end else begin
            want = '0;
            for (int c = 0; c < lcf_pkg::NUM_CH; c++) begin
                if (TARGET_REGS[c] == idx) begin
                    tgt_color[c] = val[COLOR_BITS-1:0];
                    want = lcf_pkg::DATA_W'(tgt_color[c]);
                end
            end
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d read back %0h, want %0h",
                idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_targets(input t_color_set t);
        for (int c = 0; c < lcf_pkg::NUM_CH; c++) write_reg(TARGET_REGS[c], t[c]);
    endtask

    task automatic queue_item(input logic cmd, input t_color_set now);
        t_fade_cmd it;
        it.cmd = cmd;
        it.now = now;
        fade_cmds.push_back(it);
        queued++;
    endtask

    // Waits until every queued item is accepted and its result checked.
    task automatic drain();
        do @(posedge i_clk);
        while (fed != queued || due_blends.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_color_set random_colors();
        t_color_set t;
        int unsigned r;
        for (int c = 0; c < lcf_pkg::NUM_CH; c++) begin
            r = $urandom_range(0, 7);
            t[c] = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : COLOR_BITS'($urandom_range(0, 255));
        end
        return t;
    endfunction

    // Mostly start-then-ticks sequences of random length, with some truncated ones and noise.
    task automatic random_phase();
        int unsigned r;
        int unsigned k;
        drain();
        if ($urandom_range(0, 3) != 0) set_targets(random_colors());
        if ($urandom_range(0, 3) != 0) begin
            r = $urandom_range(0, 99);
            k = (r < 10) ? 0 : (r < 20) ? 1 : (r < 25) ? 4095 :
                (r < 85) ? $urandom_range(2, 16) : $urandom_range(17, 200);
            write_reg(lcf_pkg::REG_FADE_TICKS, k);
        end
        no_gaps = ($urandom_range(0, 4) == 0);
        settings_used++;
        repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(0, 7);
            if (r == 0) begin
                repeat ($urandom_range(1, 10))
                    queue_item($urandom_range(0, 1) ? lcf_pkg::CMD_TICK
                                                    : lcf_pkg::CMD_START,
                               random_colors());
            end else begin
                k = fade_len + $urandom_range(0, 3);
                if (r == 1) k = $urandom_range(0, k);
                if (k > 60) k = 60;
                queue_item(lcf_pkg::CMD_START, random_colors());
                repeat (k) queue_item(lcf_pkg::CMD_TICK, random_colors());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero duration straight out of reset.
        queue_item(lcf_pkg::CMD_TICK, random_colors());
        drain();

        // Ticks before any start fade from zero; then a full fade with a tick past its end, and a short one.
        set_targets({8'd127, 8'd254, 8'd1, 8'd128, 8'd0, 8'd255});
        write_reg(lcf_pkg::REG_FADE_TICKS, 3);
        settings_used++;
        queue_item(lcf_pkg::CMD_TICK, {lcf_pkg::NUM_CH{8'h00}});
        queue_item(lcf_pkg::CMD_TICK, {lcf_pkg::NUM_CH{8'hFF}});
        queue_item(lcf_pkg::CMD_START, {lcf_pkg::NUM_CH{8'hFF}});
        repeat (3) queue_item(lcf_pkg::CMD_TICK, {lcf_pkg::NUM_CH{8'h00}});
        queue_item(lcf_pkg::CMD_START, {lcf_pkg::NUM_CH{8'h00}});
        queue_item(lcf_pkg::CMD_TICK, {lcf_pkg::NUM_CH{8'hFF}});
        drain();

        // Duration lowered below the tick count in the middle of a fade.
        write_reg(lcf_pkg::REG_FADE_TICKS, 1);
        settings_used++;
        queue_item(lcf_pkg::CMD_TICK, {lcf_pkg::NUM_CH{8'h55}});
        queue_item(lcf_pkg::CMD_START, {lcf_pkg::NUM_CH{8'hAA}});
        queue_item(lcf_pkg::CMD_TICK, {lcf_pkg::NUM_CH{8'h55}});
        queue_item(lcf_pkg::CMD_START, {lcf_pkg::NUM_CH{8'h55}});
        drain();

        // Longest duration, with fades both up and down.
        set_targets({8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0});
        write_reg(lcf_pkg::REG_FADE_TICKS, 4095);
        settings_used++;
        queue_item(lcf_pkg::CMD_START, {8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255});
        repeat (2) queue_item(lcf_pkg::CMD_TICK, random_colors());
        drain();

        write_reg(lcf_pkg::REG_FADE_TICKS, 0);
        settings_used++;
        queue_item(lcf_pkg::CMD_START, random_colors());
        queue_item(lcf_pkg::CMD_TICK, random_colors());

        while (queued < RANDOM_ITEMS) random_phase();
        drain();
        repeat (30) @(posedge i_clk);

        $display("Run covered %0d items (%0d starts) and %0d checked results over %0d settings.",
            fed, starts_fed, blends_seen, settings_used);
        if (errors == 0 && due_blends.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("Failures: %0d mismatches, %0d results missing.", errors, due_blends.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Run timed out with %0d items queued and %0d accepted.", queued, fed);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: linear_color_fade.f
rtl/lcf_pkg.sv
rtl/lcf_lane.sv
rtl/linear_color_fade.sv
rtl/lcf_checker.sv
sim/linear_color_fade_tb.sv
